@@ sv/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 shared definitions
// Types, constants and round tables for the message digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Initial chaining words, entry 0 is word A
  localparam logic [3:0][31:0] IV = {32'h10325476, 32'h98badcfe,
                                     32'hefcdab89, 32'h67452301};

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [31:0] PAD_WORD   = 32'h0000_0080;
  localparam logic [3:0]  LEN_LO_POS = 4'd14;
  localparam logic [3:0]  LAST_POS   = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  // Word queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WORD,
    KIND_LAST_FULL,
    KIND_LAST_PART
  } word_kind_t;

  typedef struct packed {
    word_kind_t  kind;
    logic [31:0] word;
    logic [63:0] bit_len;
  } q_entry_t;

  typedef struct packed {
    logic             fin;
    logic [15:0][31:0] words;
  } blk_t;

  typedef enum logic [2:0] {
    PS_DATA,
    PS_PAD80,
    PS_ZERO,
    PS_LEN_LO,
    PS_LEN_HI
  } pad_state_t;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_RUN,
    ES_FINISH,
    ES_EMIT
  } eng_state_t;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    logic [4:0] s;
    case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word used by a round; index math wraps mod 16
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = idx[3:0];
    case (idx[5:4])
      2'd0:    g = i4;
      2'd1:    g = (i4 << 2) + i4 + 4'd1;
      2'd2:    g = (i4 << 1) + i4 + 4'd5;
      default: g = (i4 << 3) - i4;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

@@ sv/md5_if.sv @@
// ----------------------------------------------------------------------------
// MD5 stream channels
// Valid/ready channels for message words and digests.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last;

  modport source (output valid, data_word, valid_bytes, last, input ready);
  modport sink (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  modport source (output valid, digest_high, digest_low, input ready);
  modport sink (input valid, digest_high, digest_low, output ready);
endinterface

@@ sv/md5_front.sv @@
// ----------------------------------------------------------------------------
// MD5 front end
// Counts message bytes, trims and pads the last word, and tags each beat.
// ----------------------------------------------------------------------------
module md5_front
  import md5_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        push_valid,
  input  logic        push_ready,
  output q_entry_t    push_data
);

  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

  logic [60:0] byte_len_r, byte_len_nxt;
  logic [60:0] byte_sum;
  logic [2:0]  vb_eff;
  logic [31:0] packed_word;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_comb begin
    if (!in_last) begin
      vb_eff = FULL_BYTES;
    end else if (in_valid_bytes > FULL_BYTES) begin
      vb_eff = FULL_BYTES;
    end else begin
      vb_eff = in_valid_bytes;
    end
  end

  assign byte_sum = byte_len_r + 61'(vb_eff);

  // Keep valid bytes, place the 0x80 marker right after them in a partial word
  always_comb begin
    packed_word = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < vb_eff) begin
        packed_word[8*k +: 8] = in_data_word[8*k +: 8];
      end else if (3'(k) == vb_eff) begin
        packed_word[8*k +: 8] = PAD_BYTE;
      end
    end
  end

  always_comb begin
    push_data.word    = packed_word;
    push_data.bit_len = {byte_sum, 3'b000} & LEN_MASK;
    if (!in_last) begin
      push_data.kind = KIND_WORD;
    end else if (vb_eff == FULL_BYTES) begin
      push_data.kind = KIND_LAST_FULL;
    end else begin
      push_data.kind = KIND_LAST_PART;
    end
  end

  always_comb begin
    byte_len_nxt = byte_len_r;
    if (in_valid && push_ready) begin
      byte_len_nxt = in_last ? '0 : byte_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_len_r <= '0;
    end else begin
      byte_len_r <= byte_len_nxt;
    end
  end

endmodule

@@ sv/md5_fifo.sv @@
// ----------------------------------------------------------------------------
// MD5 word queue
// Short queue of tagged beats between the front end and the padder.
// ----------------------------------------------------------------------------
module md5_fifo
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  q_entry_t [Q_DEPTH-1:0] mem_r;
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/md5_pad.sv @@
// ----------------------------------------------------------------------------
// MD5 block builder
// Fills the 16-word block buffer, appends padding and length after the last
// word, and hands each full block to the round engine.
// ----------------------------------------------------------------------------
module md5_pad
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  q_entry_t q_data,
  output logic     blk_valid,
  input  logic     blk_ready,
  output blk_t     blk
);

  pad_state_t        state_r, state_nxt;
  logic [3:0]        pos_r, pos_nxt, pos_inc;
  logic              full_r, full_nxt;
  logic              fin_r, fin_nxt;
  logic [63:0]       bit_len_r;
  logic [15:0][31:0] words_r;
  logic              wr_en;
  logic [31:0]       wr_word;
  pad_state_t        after_pad;

  assign pos_inc   = pos_r + 4'd1;
  assign after_pad = (pos_inc == LEN_LO_POS) ? PS_LEN_LO : PS_ZERO;

  assign blk_valid = full_r;
  assign blk.fin   = fin_r;
  assign blk.words = words_r;

  // Outputs: pick the word for this slot; write only while the buffer is free
  always_comb begin
    wr_en   = 1'b0;
    wr_word = '0;
    q_ready = 1'b0;
    case (state_r)
      PS_DATA: begin
        q_ready = !full_r;
        wr_en   = q_valid && !full_r;
        wr_word = q_data.word;
      end
      PS_PAD80: begin
        wr_en   = !full_r;
        wr_word = PAD_WORD;
      end
      PS_ZERO: begin
        wr_en   = !full_r;
        wr_word = '0;
      end
      PS_LEN_LO: begin
        wr_en   = !full_r;
        wr_word = bit_len_r[31:0];
      end
      PS_LEN_HI: begin
        wr_en   = !full_r;
        wr_word = bit_len_r[63:32];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (wr_en) begin
      case (state_r)
        PS_DATA: begin
          case (q_data.kind)
            KIND_LAST_FULL: state_nxt = PS_PAD80;
            KIND_LAST_PART: state_nxt = after_pad;
            default:        state_nxt = PS_DATA;
          endcase
        end
        PS_PAD80:  state_nxt = after_pad;
        PS_ZERO:   state_nxt = after_pad;
        PS_LEN_LO: state_nxt = PS_LEN_HI;
        PS_LEN_HI: state_nxt = PS_DATA;
        default:   state_nxt = PS_DATA;
      endcase
    end
  end

  always_comb begin
    pos_nxt  = wr_en ? pos_inc : pos_r;
    full_nxt = full_r;
    fin_nxt  = fin_r;
    if (wr_en && pos_r == LAST_POS) begin
      full_nxt = 1'b1;
      fin_nxt  = (state_r == PS_LEN_HI);
    end else if (full_r && blk_ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words_r[pos_r] <= wr_word;
    end
    // Latch the length when the last beat leaves the queue
    if (wr_en && state_r == PS_DATA && q_data.kind != KIND_WORD) begin
      bit_len_r <= q_data.bit_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_DATA;
      pos_r   <= '0;
      full_r  <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      full_r  <= full_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ sv/md5_round.sv @@
// ----------------------------------------------------------------------------
// MD5 round engine
// Runs the 64 compression rounds, one per cycle, folds the result into the
// chaining words and registers the digest after the final block.
// ----------------------------------------------------------------------------
module md5_round
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        blk_valid,
  output logic        blk_ready,
  input  blk_t        blk,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_high,
  output logic [63:0] out_digest_low
);

  eng_state_t        state_r, state_nxt;
  logic [5:0]        round_r, round_nxt;
  logic              fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0][31:0] msg_r;
  logic [31:0]       a_r, b_r, c_r, d_r;
  logic [3:0][31:0]  chain_r;
  logic [3:0][31:0]  chain_sum;
  logic [3:0][31:0]  seed;
  logic [63:0]       out_hi_r, out_lo_r;
  logic [31:0]       f_val, m_val, t_sum, t_rot, b_new;
  logic [63:0]       rot_wide;
  logic              take_blk, fold, load_out, out_free;

  // Round datapath
  always_comb begin
    case (round_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign m_val    = msg_r[msg_index(round_r)];
  assign t_sum    = a_r + f_val + m_val + round_const(round_r);
  assign rot_wide = {t_sum, t_sum} << rot_amount(round_r);
  assign t_rot    = rot_wide[63:32];
  assign b_new    = t_rot + b_r;

  assign chain_sum[0] = chain_r[0] + a_r;
  assign chain_sum[1] = chain_r[1] + b_r;
  assign chain_sum[2] = chain_r[2] + c_r;
  assign chain_sum[3] = chain_r[3] + d_r;
  assign seed         = (state_r == ES_FINISH) ? chain_sum : chain_r;

  assign out_free = !out_valid_r || out_ready;

  // Outputs of the sequencer
  always_comb begin
    blk_ready = 1'b0;
    fold      = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ES_IDLE: begin
        blk_ready = 1'b1;
      end
      ES_FINISH: begin
        fold      = 1'b1;
        blk_ready = !fin_r;
      end
      ES_EMIT: begin
        load_out = out_free;
      end
      default: begin
        blk_ready = 1'b0;
      end
    endcase
  end

  assign take_blk = blk_ready && blk_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ES_IDLE: begin
        if (blk_valid) state_nxt = ES_RUN;
      end
      ES_RUN: begin
        if (round_r == LAST_ROUND) state_nxt = ES_FINISH;
      end
      ES_FINISH: begin
        if (fin_r) begin
          state_nxt = ES_EMIT;
        end else if (blk_valid) begin
          state_nxt = ES_RUN;
        end else begin
          state_nxt = ES_IDLE;
        end
      end
      ES_EMIT: begin
        if (out_free) state_nxt = ES_IDLE;
      end
      default: state_nxt = ES_IDLE;
    endcase
  end

  always_comb begin
    round_nxt = round_r;
    fin_nxt   = fin_r;
    if (take_blk) begin
      round_nxt = '0;
      fin_nxt   = blk.fin;
    end else if (state_r == ES_RUN) begin
      round_nxt = round_r + 6'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_blk) begin
      msg_r <= blk.words;
      a_r   <= seed[0];
      b_r   <= seed[1];
      c_r   <= seed[2];
      d_r   <= seed[3];
    end else if (state_r == ES_RUN) begin
      a_r <= d_r;
      b_r <= b_new;
      c_r <= b_r;
      d_r <= c_r;
    end
    if (load_out) begin
      out_hi_r <= {swap32(chain_r[0]), swap32(chain_r[1])};
      out_lo_r <= {swap32(chain_r[2]), swap32(chain_r[3])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ES_IDLE;
      round_r     <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= IV;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      // Fold after each block; reload the initial words once the digest is out
      if (fold) begin
        chain_r <= chain_sum;
      end else if (load_out) begin
        chain_r <= IV;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_high = out_hi_r;
  assign out_digest_low  = out_lo_r;

endmodule

@@ sv/md5_message_digest.sv @@
// Digest: the digest of a message shows after its last beat once one or two compressions,
//   the padding words and the output register are through, and later while an earlier
//   digest still waits on the digest channel.
// Blocks: the single round unit takes a new 16-word block only after all rounds of the last;
//   beats enter one per cycle while the queue and block buffer have room.
// Reset: synchronous active-low rst_n loads the initial chaining words and clears all
//   counters and valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
// MD5 message digest
// Front end, word queue, block builder and round engine.
// ----------------------------------------------------------------------------
module md5_message_digest
  import md5_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  md5_in_if.sink       in_ch,
  md5_out_if.source    out_ch
);

  logic     push_valid, push_ready;
  q_entry_t push_data;
  logic     pop_valid, pop_ready;
  q_entry_t pop_data;
  logic     blk_valid, blk_ready;
  blk_t     blk;

  md5_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data_word   (in_ch.data_word),
    .in_valid_bytes (in_ch.valid_bytes),
    .in_last        (in_ch.last),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  md5_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  md5_pad u_pad (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  md5_round u_round (
    .clk             (clk),
    .rst_n           (rst_n),
    .blk_valid       (blk_valid),
    .blk_ready       (blk_ready),
    .blk             (blk),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_digest_high (out_ch.digest_high),
    .out_digest_low  (out_ch.digest_low)
  );

endmodule

@@ sv/md5_checker.sv @@
// ----------------------------------------------------------------------------
// MD5 port checker
// Watches the top-level channels for digest ordering and output hold.
// ----------------------------------------------------------------------------
module md5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_high,
  input logic [63:0] out_digest_low
);

  logic [3:0] pending_r;
  logic       last_beat, out_beat;

  assign last_beat = in_valid && in_ready && in_last;
  assign out_beat  = out_valid && out_ready;

  // Messages whose last beat is in but whose digest is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (last_beat && !out_beat) begin
      pending_r <= pending_r + 4'd1;
    end else if (out_beat && !last_beat) begin
      pending_r <= pending_r - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_digest_high) && $stable(out_digest_low))
    else $error("digest dropped or changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("digest offered without a finished message");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    last_beat && pending_r == 4'd0 |=> !out_valid)
    else $error("digest appeared right after the last beat");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("digest valid after reset");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last         (in_ch.last),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_high (out_ch.digest_high),
  .out_digest_low  (out_ch.digest_low)
);
